// ----- rtl/core/thpm_pkg.sv -----
`timescale 1ns / 1ps

package thpm_pkg;

  localparam int unsigned PIX_W         = 16;
  localparam int unsigned SCALE_W       = 28;
  localparam int unsigned LEN_W         = 15;
  localparam int unsigned CFG_W         = SCALE_W;
  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned TADDR_W       = 14;
  localparam int unsigned FRAC_W        = 16;
  localparam int unsigned PALETTE_BYTES = 16384;
  localparam int unsigned LEVELS        = 3000;
  localparam int unsigned AW            = $clog2(PALETTE_BYTES);
  localparam int unsigned IDX_W         = $clog2(LEVELS);
  localparam int unsigned OFF_W         = $clog2(3 * LEVELS);
  localparam int unsigned CMP_W         = (OFF_W > AW) ? OFF_W : AW;
  localparam int unsigned PROD_W        = PIX_W + SCALE_W;
  localparam int unsigned IDXR_W        = PROD_W - FRAC_W;

  localparam logic [PIX_W-1:0]   MIN_RST   = '0;
  localparam logic [PIX_W-1:0]   MAX_RST   = PIX_W'(65535);
  localparam logic [SCALE_W-1:0] SCALE_RST = SCALE_W'(3000);
  localparam logic [LEN_W-1:0]   LEN_RST   = LEN_W'(768);
  localparam logic [BYTE_W-1:0]  BYTE_WHITE = '1;
  localparam logic [BYTE_W-1:0]  BYTE_BLACK = '0;

  typedef enum logic [1:0] {
    CFG_MIN_CK      = 2'd0,
    CFG_MAX_CK      = 2'd1,
    CFG_SCALE_Q16   = 2'd2,
    CFG_PALETTE_LEN = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    CMD_MAP  = 1'b0,
    CMD_LOAD = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_BLACK = 2'd0,
    KIND_WHITE = 2'd1,
    KIND_PAL   = 2'd2
  } pix_kind_e;

  typedef struct packed {
    logic                cmd;
    logic [PIX_W-1:0]    pixel;
    logic                frame_end;
    logic [TADDR_W-1:0]  table_addr;
    logic [BYTE_W-1:0]   table_byte;
  } in_beat_t;

  typedef struct packed {
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
    logic              frame_last;
  } out_beat_t;

  typedef struct packed {
    logic [PIX_W-1:0]   min_ck;
    logic [PIX_W-1:0]   max_ck;
    logic [SCALE_W-1:0] scale_q16;
    logic [LEN_W-1:0]   palette_len;
  } cfg_t;

  typedef struct packed {
    logic               valid;
    cmd_e               cmd;
    pix_kind_e          kind;
    logic               frame_end;
    logic [AW-1:0]      table_addr;
    logic [BYTE_W-1:0]  table_byte;
    logic [AW-1:0]      off_r;
    logic [AW-1:0]      off_g;
    logic [AW-1:0]      off_b;
  } lk_req_t;

endpackage

// ----- rtl/core/thpm_ram.sv -----
`timescale 1ns / 1ps

module thpm_ram #(
  parameter int unsigned DEPTH = 16384,
  parameter int unsigned WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i && we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (en_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/thpm_index.sv -----
`timescale 1ns / 1ps

module thpm_index
  import thpm_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     adv_i,
  input  logic     in_valid_i,
  input  in_beat_t in_beat_i,
  input  cfg_t     cfg_i,
  output lk_req_t  req_o
);

  // stage 1: classify and offset from min
  logic               s1_valid_q;
  cmd_e               s1_cmd_q;
  pix_kind_e          s1_kind_q;
  pix_kind_e          s1_kind_d;
  logic               s1_fend_q;
  logic [AW-1:0]      s1_addr_q;
  logic [BYTE_W-1:0]  s1_byte_q;
  logic [PIX_W-1:0]   s1_diff_q;

  // stage 2: scaled index
  logic               s2_valid_q;
  cmd_e               s2_cmd_q;
  pix_kind_e          s2_kind_q;
  logic               s2_fend_q;
  logic [AW-1:0]      s2_addr_q;
  logic [BYTE_W-1:0]  s2_byte_q;
  logic [IDXR_W-1:0]  s2_idx_q;
  logic [PROD_W-1:0]  prod;

  // stage 3: clamped byte base
  logic               s3_valid_q;
  cmd_e               s3_cmd_q;
  pix_kind_e          s3_kind_q;
  logic               s3_fend_q;
  logic [AW-1:0]      s3_addr_q;
  logic [BYTE_W-1:0]  s3_byte_q;
  logic [OFF_W-1:0]   s3_base_q;
  logic [IDX_W-1:0]   idx_clamp;

  // stage 4: clamped offsets
  lk_req_t            s4_q;
  logic [CMP_W-1:0]   lim;
  logic [CMP_W-1:0]   o_r;
  logic [CMP_W-1:0]   o_g;
  logic [CMP_W-1:0]   o_b;

  always_comb begin
    if (in_beat_i.pixel == '0) begin
      s1_kind_d = KIND_BLACK;
    end else if (in_beat_i.pixel <= cfg_i.min_ck) begin
      s1_kind_d = KIND_WHITE;
    end else if (in_beat_i.pixel >= cfg_i.max_ck) begin
      s1_kind_d = KIND_BLACK;
    end else begin
      s1_kind_d = KIND_PAL;
    end
  end

  assign prod = PROD_W'(s1_diff_q) * PROD_W'(cfg_i.scale_q16);

  assign idx_clamp = (s2_idx_q > IDXR_W'(LEVELS - 1)) ? IDX_W'(LEVELS - 1)
                                                      : s2_idx_q[IDX_W-1:0];

  always_comb begin
    if (cfg_i.palette_len == '0) begin
      lim = '0;
    end else if (32'(cfg_i.palette_len) > 32'(PALETTE_BYTES)) begin
      lim = CMP_W'(PALETTE_BYTES - 1);
    end else begin
      lim = CMP_W'(cfg_i.palette_len - 1'b1);
    end
    o_r = CMP_W'(s3_base_q);
    o_g = CMP_W'(s3_base_q) + CMP_W'(1);
    o_b = CMP_W'(s3_base_q) + CMP_W'(2);
    if (o_r > lim) o_r = lim;
    if (o_g > lim) o_g = lim;
    if (o_b > lim) o_b = lim;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_q        <= '0;
    end else if (adv_i) begin
      s1_valid_q  <= in_valid_i;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;

      s4_q.valid      <= s3_valid_q;
      s4_q.cmd        <= s3_cmd_q;
      s4_q.kind       <= s3_kind_q;
      s4_q.frame_end  <= s3_fend_q;
      s4_q.table_addr <= s3_addr_q;
      s4_q.table_byte <= s3_byte_q;
      s4_q.off_r      <= AW'(o_r);
      s4_q.off_g      <= AW'(o_g);
      s4_q.off_b      <= AW'(o_b);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_cmd_q  <= cmd_e'(in_beat_i.cmd);
      s1_kind_q <= s1_kind_d;
      s1_fend_q <= in_beat_i.frame_end;
      s1_addr_q <= AW'(in_beat_i.table_addr);
      s1_byte_q <= in_beat_i.table_byte;
      s1_diff_q <= in_beat_i.pixel - cfg_i.min_ck;

      s2_cmd_q  <= s1_cmd_q;
      s2_kind_q <= s1_kind_q;
      s2_fend_q <= s1_fend_q;
      s2_addr_q <= s1_addr_q;
      s2_byte_q <= s1_byte_q;
      s2_idx_q  <= prod[PROD_W-1:FRAC_W];

      s3_cmd_q  <= s2_cmd_q;
      s3_kind_q <= s2_kind_q;
      s3_fend_q <= s2_fend_q;
      s3_addr_q <= s2_addr_q;
      s3_byte_q <= s2_byte_q;
      s3_base_q <= OFF_W'(idx_clamp) * OFF_W'(3);
    end
  end

  assign req_o = s4_q;

endmodule

// ----- rtl/core/thermal_palette_mapper_unit.sv -----
`timescale 1ns / 1ps
// Channel  Signals                                   Width  Direction
// in       in_valid_i / in_stall_o / in_beat_i       40     in
// out      out_valid_o / out_stall_i / out_beat_o    25     out
// cfg      cfg_we_i / cfg_idx_i / cfg_data_i         2+28   in
//
// One beat per cycle unless an output stall holds the pipeline; a pixel beat passes
// classify, multiply, clamp, offsets, three palette RAM reads and output stages.
// Palette loads write in order with pixel reads, so a read sees all earlier loads.
// Reset clears valid bits and sets config to its defaults; the palette RAM holds no reset value.
// An output stall with a valid output beat freezes every stage at once; bubbles stay in place.

module thermal_palette_mapper_unit
  import thpm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_beat_t         in_beat_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_beat_t        out_beat_o,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  cfg_t              cfg_q;
  logic              adv;
  lk_req_t           req;
  logic              ram_we;
  logic [AW-1:0]     addr_r;
  logic [AW-1:0]     addr_g;
  logic [AW-1:0]     addr_b;
  logic [BYTE_W-1:0] rd_r;
  logic [BYTE_W-1:0] rd_g;
  logic [BYTE_W-1:0] rd_b;
  logic              s5_valid_q;
  cmd_e              s5_cmd_q;
  pix_kind_e         s5_kind_q;
  logic              s5_fend_q;
  logic              out_valid_q;
  logic              out_valid_d;
  out_beat_t         out_q;
  out_beat_t         out_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_ck      <= MIN_RST;
      cfg_q.max_ck      <= MAX_RST;
      cfg_q.scale_q16   <= SCALE_RST;
      cfg_q.palette_len <= LEN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_MIN_CK:      cfg_q.min_ck      <= cfg_data_i[PIX_W-1:0];
        CFG_MAX_CK:      cfg_q.max_ck      <= cfg_data_i[PIX_W-1:0];
        CFG_SCALE_Q16:   cfg_q.scale_q16   <= cfg_data_i[SCALE_W-1:0];
        CFG_PALETTE_LEN: cfg_q.palette_len <= cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;

  thpm_index u_index (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .in_valid_i (in_valid_i),
    .in_beat_i  (in_beat_i),
    .cfg_i      (cfg_q),
    .req_o      (req)
  );

  assign ram_we = req.valid && (req.cmd == CMD_LOAD);
  assign addr_r = (req.cmd == CMD_LOAD) ? req.table_addr : req.off_r;
  assign addr_g = (req.cmd == CMD_LOAD) ? req.table_addr : req.off_g;
  assign addr_b = (req.cmd == CMD_LOAD) ? req.table_addr : req.off_b;

  thpm_ram #(.DEPTH(PALETTE_BYTES), .WIDTH(BYTE_W)) u_ram_r (
    .clk_i   (clk_i),
    .en_i    (adv),
    .we_i    (ram_we),
    .addr_i  (addr_r),
    .wdata_i (req.table_byte),
    .rdata_o (rd_r)
  );

  thpm_ram #(.DEPTH(PALETTE_BYTES), .WIDTH(BYTE_W)) u_ram_g (
    .clk_i   (clk_i),
    .en_i    (adv),
    .we_i    (ram_we),
    .addr_i  (addr_g),
    .wdata_i (req.table_byte),
    .rdata_o (rd_g)
  );

  thpm_ram #(.DEPTH(PALETTE_BYTES), .WIDTH(BYTE_W)) u_ram_b (
    .clk_i   (clk_i),
    .en_i    (adv),
    .we_i    (ram_we),
    .addr_i  (addr_b),
    .wdata_i (req.table_byte),
    .rdata_o (rd_b)
  );

  always_comb begin
    out_valid_d      = s5_valid_q && (s5_cmd_q == CMD_MAP);
    out_d.frame_last = s5_fend_q;
    case (s5_kind_q)
      KIND_PAL: begin
        out_d.red   = rd_r;
        out_d.green = rd_g;
        out_d.blue  = rd_b;
      end
      KIND_WHITE: begin
        out_d.red   = BYTE_WHITE;
        out_d.green = BYTE_WHITE;
        out_d.blue  = BYTE_WHITE;
      end
      default: begin
        out_d.red   = BYTE_BLACK;
        out_d.green = BYTE_BLACK;
        out_d.blue  = BYTE_BLACK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s5_valid_q  <= req.valid;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s5_cmd_q  <= req.cmd;
      s5_kind_q <= req.kind;
      s5_fend_q <= req.frame_end;
      out_q     <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

endmodule
